[rtl/blr_pkg.sv]
// Shared constants and types of the bitmap label rasteriser.
`timescale 1ns / 1ps
`default_nettype none
package blr_pkg;

	localparam int GLYPH_ROWS    = 7;
	localparam int GLYPH_COLS    = 5;
	localparam int GLYPH_BITS    = GLYPH_ROWS * GLYPH_COLS;
	localparam int MAX_CHARS_DEF = 32;
	localparam int COORD_W       = 16;
	localparam int SCALE_W       = 8;
	localparam int COLOR_W       = 24;
	localparam int CODE_W        = 8;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 24;
	localparam int ADVANCE_COLS  = 6;

	typedef logic [GLYPH_BITS-1:0] glyph_mask_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X    = 2'd0,
		CFG_ORIGIN_Y    = 2'd1,
		CFG_PIXEL_SCALE = 2'd2,
		CFG_INK_COLOR   = 2'd3
	} cfg_index_t;

endpackage
`default_nettype wire

[rtl/blr_glyph_rom.sv]
// Character code to 5x7 glyph bitmap lookup, top row in the most significant bits.
`timescale 1ns / 1ps
`default_nettype none
module blr_glyph_rom (
	input  wire logic [blr_pkg::CODE_W-1:0] code,
	output blr_pkg::glyph_mask_t            mask
);
	import blr_pkg::*;

	always_comb begin
		case (code)
			8'h41: mask = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11}; // A
			8'h42: mask = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e}; // B
			8'h43: mask = {5'h0f, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0f}; // C
			8'h44: mask = {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e}; // D
			8'h45: mask = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f}; // E
			8'h47: mask = {5'h0f, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f}; // G
			8'h48: mask = {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11}; // H
			8'h49: mask = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1f}; // I
			8'h4d: mask = {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11}; // M
			8'h4e: mask = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11}; // N
			8'h4f: mask = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e}; // O
			8'h50: mask = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10}; // P
			8'h52: mask = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11}; // R
			8'h53: mask = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e}; // S
			8'h54: mask = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}; // T
			8'h55: mask = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e}; // U
			8'h56: mask = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04}; // V
			8'h5a: mask = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f}; // Z
			default: mask = '0;
		endcase
	end

endmodule
`default_nettype wire

[rtl/bitmap_label_rasterizer.sv]
// Top level of the bitmap label rasteriser: glyph scan sequencer and stream ports.
`timescale 1ns / 1ps
`default_nettype none
// Each input transaction carries one character code, with tuser marking the start of a
// new label. A known glyph is scanned one pixel position per cycle, while the output is not
// stalled, over its 7 rows by 5 columns, and every lit pixel leaves as one square fill
// command; the final square of a character carries tlast. With a non-zero scale and the
// label under its character limit, a character is taken in the idle state, scanned in 35
// steps that wait whenever the output is stalled, and then the cursor moves on; otherwise
// the block stays idle after taking it. The scan uses one shared 16-bit adder, which steps
// the column and row offsets and then the cursor. The input is ready only between characters.
module bitmap_label_rasterizer #(
	parameter int MAX_CHARS = blr_pkg::MAX_CHARS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration write channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [blr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [blr_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Character input
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [blr_pkg::CODE_W-1:0]      s_axis_tdata,  // [7:0] char_code
	input  wire logic                            s_axis_tuser,  // [0] label_start
	// Square fill commands
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [63:0]                          m_axis_tdata,  // [15:0] square_x,
	                                                            // [31:16] square_y,
	                                                            // [39:32] square_side,
	                                                            // [63:40] square_color
	output logic                                 m_axis_tlast   // last_of_char
);
	import blr_pkg::*;

	localparam int CNT_W = $clog2(MAX_CHARS + 1);
	localparam int COL_W = $clog2(GLYPH_COLS);
	localparam int ROW_W = $clog2(GLYPH_ROWS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ADV
	} state_t;

	state_t               state_q;
	logic [COORD_W-1:0]   origin_x_q, origin_y_q;
	logic [SCALE_W-1:0]   scale_q;
	logic [COLOR_W-1:0]   color_q;
	logic [COORD_W-1:0]   cursor_q;
	logic [CNT_W-1:0]     count_q;
	logic [COORD_W-1:0]   x_q, y_q;
	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	glyph_mask_t          mask_q;
	logic                 out_valid_q;
	logic [COORD_W-1:0]   out_x_q, out_y_q;
	logic [SCALE_W-1:0]   out_side_q;
	logic [COLOR_W-1:0]   out_color_q;
	logic                 out_last_q;

	glyph_mask_t          glyph_mask;
	logic                 in_fire;
	logic [CNT_W-1:0]     count_base;
	logic                 char_active;
	logic                 step;
	logic                 emit;
	logic                 row_end;
	logic [COORD_W-1:0]   add_a, add_b, add_sum;
	logic [COORD_W-1:0]   scale_ext, scale_x6;

	blr_glyph_rom u_glyph_rom (
		.code (s_axis_tdata),
		.mask (glyph_mask)
	);

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign count_base    = s_axis_tuser ? '0 : count_q;
	assign char_active   = (count_base < CNT_W'(MAX_CHARS));

	// A scan step goes ahead only when the output register is free or being emptied.
	assign step    = (state_q == ST_SCAN) && (!out_valid_q || m_axis_tready);
	assign emit    = step && mask_q[GLYPH_BITS-1];
	assign row_end = (col_q == COL_W'(GLYPH_COLS - 1));

	// Shared adder: column step on x, row step on y, cursor advance at the end.
	assign scale_ext = COORD_W'(scale_q);
	assign scale_x6  = (scale_ext << 2) + (scale_ext << 1);
	always_comb begin
		add_a = x_q;
		add_b = scale_ext;
		case (state_q)
			ST_SCAN: begin
				if (row_end) begin
					add_a = y_q;
				end
			end
			ST_ADV: begin
				add_a = cursor_q;
				add_b = scale_x6;
			end
			default: begin
				add_a = x_q;
			end
		endcase
	end
	assign add_sum = add_a + add_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			scale_q     <= SCALE_W'(1);
			color_q     <= '0;
			cursor_q    <= '0;
			count_q     <= '0;
			x_q         <= '0;
			y_q         <= '0;
			col_q       <= '0;
			row_q       <= '0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_side_q  <= '0;
			out_color_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ORIGIN_X:    origin_x_q <= cfg_data[COORD_W-1:0];
					CFG_ORIGIN_Y:    origin_y_q <= cfg_data[COORD_W-1:0];
					CFG_PIXEL_SCALE: scale_q    <= cfg_data[SCALE_W-1:0];
					CFG_INK_COLOR:   color_q    <= cfg_data[COLOR_W-1:0];
					default:         color_q    <= color_q;
				endcase
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (s_axis_tuser) begin
							cursor_q <= origin_x_q;
						end
						if (char_active) begin
							count_q <= count_base + CNT_W'(1);
						end else begin
							count_q <= count_base;
						end
						x_q    <= s_axis_tuser ? origin_x_q : cursor_q;
						y_q    <= origin_y_q;
						col_q  <= '0;
						row_q  <= '0;
						mask_q <= glyph_mask;
						if (char_active && (scale_q != '0)) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (step) begin
						if (mask_q[GLYPH_BITS-1]) begin
							out_x_q     <= x_q;
							out_y_q     <= y_q;
							out_side_q  <= scale_q;
							out_color_q <= color_q;
							out_last_q  <= (mask_q[GLYPH_BITS-2:0] == '0);
						end
						mask_q <= mask_q << 1;
						if (row_end) begin
							col_q <= '0;
							x_q   <= cursor_q;
							y_q   <= add_sum;
							if (row_q == ROW_W'(GLYPH_ROWS - 1)) begin
								row_q   <= '0;
								state_q <= ST_ADV;
							end else begin
								row_q <= row_q + ROW_W'(1);
							end
						end else begin
							col_q <= col_q + COL_W'(1);
							x_q   <= add_sum;
						end
					end
				end
				ST_ADV: begin
					cursor_q <= add_sum;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_color_q, out_side_q, out_y_q, out_x_q};
	assign m_axis_tlast  = out_last_q;

	// The character count never passes the label limit.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_CHARS))
		else $error("character count beyond label limit");

	// By the cursor advance every glyph pixel has been scanned and the counters wrapped.
	a_adv_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV) |-> (mask_q == '0 && col_q == '0 && row_q == '0))
		else $error("cursor advance before glyph scan complete");

	// A stalled output is never overwritten by the scan.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_x_q)
			&& $stable(out_y_q) && $stable(out_last_q)))
		else $error("pending square overwritten");

endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench of the bitmap label rasteriser, with its square fill command tracker.
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
	logic [15:0] x;
	logic [15:0] y;
	logic [7:0]  side;
	logic [23:0] color;
	logic        last;
} square_cmd_t;

// Keeps a private copy of the registers and the cursor, turns every accepted character
// into the squares it should produce and compares the block's squares against them.
class fill_command_tracker;
	logic [15:0] origin_x;
	logic [15:0] origin_y;
	logic [7:0]  pixel_scale;
	logic [23:0] ink_color;
	logic [15:0] pen_x;
	int          chars_in_label;
	square_cmd_t pending_squares[$];
	int          errors;
	int          squares_checked;
	int          chars_drawn;
	int          chars_dropped;
	int          zero_scale_chars;

	function new();
		origin_x         = '0;
		origin_y         = '0;
		pixel_scale      = 8'd1;
		ink_color        = '0;
		pen_x            = '0;
		chars_in_label   = 0;
		errors           = 0;
		squares_checked  = 0;
		chars_drawn      = 0;
		chars_dropped    = 0;
		zero_scale_chars = 0;
	endfunction

	// Rows top to bottom, most significant column bit on the left of each row.
	static function logic [34:0] glyph_of(logic [7:0] code);
		case (code)
			"A": return {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
			"B": return {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
			"C": return {5'h0f, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0f};
			"D": return {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
			"E": return {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
			"G": return {5'h0f, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f};
			"H": return {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
			"I": return {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1f};
			"M": return {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
			"N": return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
			"O": return {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
			"P": return {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
			"R": return {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
			"S": return {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
			"T": return {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
			"U": return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
			"V": return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04};
			"Z": return {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f};
			default: return '0;
		endcase
	endfunction

	function void write_reg(blr_pkg::cfg_index_t idx, logic [23:0] data);
		case (idx)
			blr_pkg::CFG_ORIGIN_X:    origin_x    = data[15:0];
			blr_pkg::CFG_ORIGIN_Y:    origin_y    = data[15:0];
			blr_pkg::CFG_PIXEL_SCALE: pixel_scale = data[7:0];
			blr_pkg::CFG_INK_COLOR:   ink_color   = data;
			default: ;
		endcase
	endfunction

	function void take_char(logic [7:0] code, logic label_start);
		logic [34:0] mask;
		square_cmd_t sq;
		int          added;
		added = 0;
		if (label_start) begin
			pen_x          = origin_x;
			chars_in_label = 0;
		end
		if (chars_in_label >= blr_pkg::MAX_CHARS_DEF) begin
			chars_dropped++;
			return;
		end
		chars_in_label++;
		chars_drawn++;
		// A zero scale still uses up a character slot but leaves the cursor where it is.
		if (pixel_scale == 8'd0) begin
			zero_scale_chars++;
			return;
		end
		mask = glyph_of(code);
		for (int row = 0; row < blr_pkg::GLYPH_ROWS; row++) begin
			for (int col = 0; col < blr_pkg::GLYPH_COLS; col++) begin
				if (mask[34 - 5 * row - col]) begin
					sq.x     = pen_x + 16'(col) * 16'(pixel_scale);
					sq.y     = origin_y + 16'(row) * 16'(pixel_scale);
					sq.side  = pixel_scale;
					sq.color = ink_color;
					sq.last  = 1'b0;
					pending_squares.push_back(sq);
					added++;
				end
			end
		end
		if (added > 0)
			pending_squares[pending_squares.size() - 1].last = 1'b1;
		pen_x = pen_x + 16'(blr_pkg::ADVANCE_COLS) * 16'(pixel_scale);
	endfunction

	function void check_square(logic [63:0] data, logic last);
		square_cmd_t want;
		if (pending_squares.size() == 0) begin
			$error("square with no expected command: x=%h y=%h side=%h color=%h last=%b",
				data[15:0], data[31:16], data[39:32], data[63:40], last);
			errors++;
			return;
		end
		want = pending_squares.pop_front();
		squares_checked++;
		if (data[15:0] !== want.x) begin
			$error("square_x: expected %h, actual %h", want.x, data[15:0]);
			errors++;
		end
		if (data[31:16] !== want.y) begin
			$error("square_y: expected %h, actual %h", want.y, data[31:16]);
			errors++;
		end
		if (data[39:32] !== want.side) begin
			$error("square_side: expected %h, actual %h", want.side, data[39:32]);
			errors++;
		end
		if (data[63:40] !== want.color) begin
			$error("square_color: expected %h, actual %h", want.color, data[63:40]);
			errors++;
		end
		if (last !== want.last) begin
			$error("last_of_char: expected %b, actual %b", want.last, last);
			errors++;
		end
	endfunction

	function int pending();
		return pending_squares.size();
	endfunction
endclass

module tb;
	localparam int SETTLE_CYCLES = 60;
	localparam int STALL_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 400;
	localparam int TARGET_CHARS  = 350;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        cfg_valid      = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index      = '0;
	logic [23:0] cfg_data       = '0;
	logic        s_axis_tvalid  = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata   = '0;
	logic        s_axis_tuser   = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready  = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tlast;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit          hold_req      = 1'b0;
	bit          hold_done     = 1'b0;
	int          hold_left     = 0;
	int          max_scale_seen = 0;
	int          min_scale_seen = 255;

	fill_command_tracker sb = new();

	string rom_letters = "ABCDEGHIMNOPRSTUVZ";

	bitmap_label_rasterizer #(
		.MAX_CHARS(blr_pkg::MAX_CHARS_DEF)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Squares are checked before a new character is noted, so that a transaction on both
	// sides at one edge is always handled in stream order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_square(m_axis_tdata, m_axis_tlast);
			if (s_axis_tvalid && s_axis_tready)
				sb.take_char(s_axis_tdata, s_axis_tuser);
		end
	end

	// Output back-pressure, including one long hold-off that lets the block fill up.
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready = 1'b0;
		end else begin
			m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				stall = 0;
			else
				stall++;
		end
		$display("Timed out after %0d cycles with no transaction", STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic write_reg(blr_pkg::cfg_index_t idx, logic [23:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, data);
		if (idx == blr_pkg::CFG_PIXEL_SCALE) begin
			if (int'(data[7:0]) > max_scale_seen) max_scale_seen = int'(data[7:0]);
			if (int'(data[7:0]) < min_scale_seen) min_scale_seen = int'(data[7:0]);
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Returns at a falling edge with tvalid still high, so the next character can follow
	// without a gap; anything else must lower tvalid straight away.
	task automatic send_char(logic [7:0] code, logic label_start);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = code;
		s_axis_tuser  = label_start;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	// A blank character keeps the block busy without producing anything, hence the extra
	// cycles after the last expected square.
	task automatic wait_idle();
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic program_random_setting();
		int          pick;
		logic [23:0] val;
		pick = $urandom_range(99);
		if (pick < 50)      val = 24'($urandom_range(1, 3));
		else if (pick < 62) val = 24'd0;
		else if (pick < 74) val = 24'd255;
		else                val = 24'($urandom_range(4, 40));
		write_reg(blr_pkg::CFG_PIXEL_SCALE, val);
		pick = $urandom_range(3);
		val  = (pick == 0) ? 24'h0 : (pick == 1) ? 24'($urandom_range(16'hFF00, 16'hFFFF))
			: 24'($urandom_range(0, 16'hFFFF));
		write_reg(blr_pkg::CFG_ORIGIN_X, val);
		pick = $urandom_range(3);
		val  = (pick == 0) ? 24'h0 : (pick == 1) ? 24'($urandom_range(16'hFF00, 16'hFFFF))
			: 24'($urandom_range(0, 16'hFFFF));
		write_reg(blr_pkg::CFG_ORIGIN_Y, val);
		pick = $urandom_range(3);
		val  = (pick == 0) ? 24'h0 : (pick == 1) ? 24'hFFFFFF : 24'($urandom);
		write_reg(blr_pkg::CFG_INK_COLOR, val);
	endtask

	task automatic send_random_label(int len);
		logic [7:0] code;
		logic       restart;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 80)
				code = rom_letters[$urandom_range(rom_letters.len() - 1)];
			else
				code = 8'($urandom);
			// Now and then a stray label start lands in the middle of a label.
			restart = (i == 0) || ($urandom_range(99) < 4);
			send_char(code, restart);
		end
	endtask

	initial begin
		int quota;
		int len;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: scale one at the origin, black ink.
		send_char("A", 1'b1);
		send_char("Z", 1'b0);
		wait_idle();

		// Largest scale, full colour and origins near the top so that coordinates wrap.
		write_reg(blr_pkg::CFG_ORIGIN_X, 24'h00FFF0);
		write_reg(blr_pkg::CFG_ORIGIN_Y, 24'h00FFFC);
		write_reg(blr_pkg::CFG_PIXEL_SCALE, 24'd255);
		write_reg(blr_pkg::CFG_INK_COLOR, 24'hFFFFFF);
		send_char("M", 1'b1);
		send_char("I", 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char("W", 1'b0);
		send_char("a", 1'b0);
		wait_idle();

		// Zero scale: characters count but nothing moves.
		write_reg(blr_pkg::CFG_PIXEL_SCALE, 24'd0);
		send_char("B", 1'b0);
		send_char("H", 1'b0);
		wait_idle();

		write_reg(blr_pkg::CFG_PIXEL_SCALE, 24'd2);
		write_reg(blr_pkg::CFG_ORIGIN_X, 24'h0);
		write_reg(blr_pkg::CFG_ORIGIN_Y, 24'h0);
		write_reg(blr_pkg::CFG_INK_COLOR, 24'h5AA53C);
		send_char("O", 1'b0);
		send_char("E", 1'b0);
		send_char(8'h80, 1'b0);
		send_char("S", 1'b1);
		wait_idle();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 36; recv_idle_pct = 80; end
				1: begin send_idle_pct = 80; recv_idle_pct = 36; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			quota = sb.chars_drawn + TARGET_CHARS / 3;
			while (sb.chars_drawn < quota) begin
				wait_idle();
				program_random_setting();
				// The long hold-off only fills the block when squares are being drawn.
				if (phase == 2 && sb.pixel_scale != 8'd0)
					hold_req = 1'b1;
				for (int lbl = 0; lbl < $urandom_range(1, 3); lbl++) begin
					// The first label of a phase runs past the character limit.
					len = (lbl == 0 && quota - sb.chars_drawn == TARGET_CHARS / 3)
						? $urandom_range(blr_pkg::MAX_CHARS_DEF + 1, 40)
						: $urandom_range(1, 12);
					send_random_label(len);
				end
			end
		end
		wait_idle();

		$display("Run took %0d characters, dropped %0d past the label limit, %0d at zero scale",
			sb.chars_drawn, sb.chars_dropped, sb.zero_scale_chars);
		$display("%0d squares checked; scales %0d..%0d; three idle mixes, one long hold-off",
			sb.squares_checked, min_scale_seen, max_scale_seen);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
